FILE: hdl/adagrad_weight_update_top_defines.svh
// Assertion macros shared by the Adagrad weight update RTL.
`ifndef ADAGRAD_WEIGHT_UPDATE_TOP_DEFINES_SVH
`define ADAGRAD_WEIGHT_UPDATE_TOP_DEFINES_SVH

// Implication checked in the same cycle.
`define AWU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Implication checked in the following cycle.
`define AWU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/awu_pkg.sv
// Types and constants of the Adagrad weight update block.
package awu_pkg;

  localparam int NUM_WEIGHTS = 1024;
  localparam int INDEX_W     = $clog2(NUM_WEIGHTS);
  localparam int FRAC_BITS   = 24;
  localparam int DATA_W      = 32;
  localparam int LR_W        = 25;
  localparam int FUDGE_W     = 24;
  localparam int ACC_W       = 48;
  localparam int D_W         = ACC_W + 1;
  localparam int SQ_W        = 2 * DATA_W - FRAC_BITS;
  localparam int ROOT_W      = (D_W + FRAC_BITS + 1) / 2;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int SUB_W       = ROOT_W + 3;
  localparam int PROD_W      = LR_W + DATA_W;
  localparam int NW_W        = PROD_W + 2;
  localparam int STEP_CNT_W  = $clog2(PROD_W);

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = LR_W;

  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_ACCUM    = 1'b1;

  localparam logic [LR_W-1:0]    LEARNING_RATE_RST = LR_W'(167772);
  localparam logic [FUDGE_W-1:0] INIT_ACCUM_RST    = FUDGE_W'(17);

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQ,
    ST_ACC,
    ST_SQRT,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_e;

endpackage

FILE: hdl/awu_if.sv
// Request and result channel interfaces of the Adagrad weight update block.
interface awu_in_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic [awu_pkg::INDEX_W-1:0]       weight_index;
  logic signed [awu_pkg::DATA_W-1:0] weight;
  logic signed [awu_pkg::DATA_W-1:0] gradient;

  modport source (output valid, action, weight_index, weight, gradient, input ready);
  modport sink (input valid, action, weight_index, weight, gradient, output ready);
endinterface

interface awu_out_if;
  logic                              valid;
  logic                              ready;
  logic [awu_pkg::INDEX_W-1:0]       result_index;
  logic signed [awu_pkg::DATA_W-1:0] new_weight;
  logic                              saturated;

  modport source (output valid, result_index, new_weight, saturated, input ready);
  modport sink (input valid, result_index, new_weight, saturated, output ready);
endinterface

FILE: hdl/adagrad_weight_update_top.sv
// Adagrad weight update engine with a per-weight squared-gradient store.
// After reset the block sweeps its 1024-entry accumulator memory to zero, one
// entry a cycle, and accepts no item until the sweep is done. An update item
// then runs from acceptance to its result through one multiplier pass for the
// squared gradient, a read-modify-write of the accumulator, a bit-pair square
// root and a restoring division, both on a single shared subtractor, with one
// shared 32 by 32 multiplier. A clear item zeroes its entry when it is accepted
// and then goes to the result. The result waits in an output register, so the
// next item is accepted while the previous result has not yet been taken.
`include "adagrad_weight_update_top_defines.svh"

module adagrad_weight_update_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [awu_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [awu_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  awu_in_if.sink                           req_i,
  awu_out_if.source                        rsp_o
);

  localparam int INDEX_W    = awu_pkg::INDEX_W;
  localparam int DATA_W     = awu_pkg::DATA_W;
  localparam int ACC_W      = awu_pkg::ACC_W;
  localparam int D_W        = awu_pkg::D_W;
  localparam int SQ_W       = awu_pkg::SQ_W;
  localparam int ROOT_W     = awu_pkg::ROOT_W;
  localparam int RAD_W      = awu_pkg::RAD_W;
  localparam int SUB_W      = awu_pkg::SUB_W;
  localparam int PROD_W     = awu_pkg::PROD_W;
  localparam int NW_W       = awu_pkg::NW_W;
  localparam int STEP_CNT_W = awu_pkg::STEP_CNT_W;
  localparam int FRAC_BITS  = awu_pkg::FRAC_BITS;

  awu_pkg::state_e state_q, state_d;

  logic [awu_pkg::LR_W-1:0]    lr_q;
  logic [awu_pkg::FUDGE_W-1:0] init_q;

  logic [INDEX_W-1:0]    clr_addr_q;
  logic [STEP_CNT_W-1:0] cnt_q;

  logic [INDEX_W-1:0] idx_q;
  logic [DATA_W-1:0]  w_q;
  logic               gneg_q;
  logic [DATA_W-1:0]  gmag_q;
  logic               sat_q;
  logic [DATA_W-1:0]  nw_q;
  logic [SQ_W-1:0]    sq_q;
  logic [RAD_W-1:0]   rad_q;
  logic [SUB_W-1:0]   rem_q;
  logic [ROOT_W-1:0]  root_q;
  logic [PROD_W-1:0]  quo_q;

  logic               out_valid_q;
  logic [INDEX_W-1:0] out_idx_q;
  logic [DATA_W-1:0]  out_nw_q;
  logic               out_sat_q;

  logic [ACC_W-1:0] mem [awu_pkg::NUM_WEIGHTS];
  logic [ACC_W-1:0] rdata_q;
  logic             mem_we;
  logic [INDEX_W-1:0] mem_waddr;
  logic [ACC_W-1:0] mem_wdata;

  logic                accept;
  logic                load_out;
  logic [DATA_W-1:0]   mul_a, mul_b;
  logic [2*DATA_W-1:0] mul_res;
  logic [SUB_W-1:0]    sub_a, sub_b;
  logic [SUB_W:0]      sub_res;
  logic                borrow;
  logic [SUB_W-1:0]    diff;
  logic [DATA_W-1:0]   gmag_in;
  logic [ACC_W:0]      acc_sum;
  logic                acc_ovf;
  logic [ACC_W-1:0]    acc_new;
  logic [D_W-1:0]      d_val;
  logic [ROOT_W-1:0]   div_s;
  logic [NW_W-1:0]     wext, magx, nw_full;
  logic                nw_in_range;
  logic [DATA_W-1:0]   nw_clamped;

  assign accept  = req_i.valid && req_i.ready;
  assign gmag_in = req_i.gradient[DATA_W-1] ? (~req_i.gradient + DATA_W'(1))
                                            : req_i.gradient;

  assign mul_res = mul_a * mul_b;
  assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow  = sub_res[SUB_W];
  assign diff    = sub_res[SUB_W-1:0];

  assign acc_sum = {1'b0, rdata_q} + (ACC_W + 1)'(sq_q);
  assign acc_ovf = acc_sum[ACC_W];
  assign acc_new = acc_ovf ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
  assign d_val   = D_W'(acc_new) + D_W'(init_q);

  assign div_s = (root_q == '0) ? ROOT_W'(1) : root_q;

  assign wext    = {{(NW_W - DATA_W){w_q[DATA_W-1]}}, w_q};
  assign magx    = {2'b00, quo_q};
  assign nw_full = gneg_q ? (wext + magx) : (wext - magx);
  assign nw_in_range = (&nw_full[NW_W-1:DATA_W-1]) || !(|nw_full[NW_W-1:DATA_W-1]);
  assign nw_clamped  = nw_in_range ? nw_full[DATA_W-1:0]
                     : (nw_full[NW_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                        : {1'b0, {(DATA_W-1){1'b1}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= awu_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    load_out    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = '0;
    mul_a       = gmag_q;
    mul_b       = gmag_q;
    sub_a       = {rem_q[SUB_W-3:0], rad_q[RAD_W-1 -: 2]};
    sub_b       = SUB_W'({root_q, 2'b01});
    unique case (state_q)
      awu_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        if (clr_addr_q == INDEX_W'(awu_pkg::NUM_WEIGHTS - 1)) begin
          state_d = awu_pkg::ST_IDLE;
        end
      end
      awu_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          case (req_i.action)
            awu_pkg::ACT_CLEAR: begin
              mem_we    = 1'b1;
              mem_waddr = req_i.weight_index;
              state_d   = awu_pkg::ST_DONE;
            end
            awu_pkg::ACT_UPDATE: state_d = awu_pkg::ST_SQ;
            default:             state_d = awu_pkg::ST_IDLE;
          endcase
        end
      end
      awu_pkg::ST_SQ: state_d = awu_pkg::ST_ACC;
      awu_pkg::ST_ACC: begin
        mem_we    = 1'b1;
        mem_wdata = acc_new;
        state_d   = awu_pkg::ST_SQRT;
      end
      awu_pkg::ST_SQRT: begin
        if (cnt_q == STEP_CNT_W'(ROOT_W - 1)) begin
          state_d = awu_pkg::ST_MUL;
        end
      end
      awu_pkg::ST_MUL: begin
        mul_a   = DATA_W'(lr_q);
        state_d = awu_pkg::ST_DIV;
      end
      awu_pkg::ST_DIV: begin
        sub_a = SUB_W'({rem_q[ROOT_W-1:0], quo_q[PROD_W-1]});
        sub_b = SUB_W'(div_s);
        if (cnt_q == STEP_CNT_W'(PROD_W - 1)) begin
          state_d = awu_pkg::ST_FIN;
        end
      end
      awu_pkg::ST_FIN: state_d = awu_pkg::ST_DONE;
      awu_pkg::ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = awu_pkg::ST_IDLE;
        end
      end
      default: state_d = awu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q        <= awu_pkg::LEARNING_RATE_RST;
      init_q      <= awu_pkg::INIT_ACCUM_RST;
      clr_addr_q  <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          awu_pkg::REG_LEARNING_RATE: lr_q   <= cfg_data_i;
          awu_pkg::REG_INIT_ACCUM:    init_q <= cfg_data_i[awu_pkg::FUDGE_W-1:0];
          default: ;
        endcase
      end
      if (state_q == awu_pkg::ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + INDEX_W'(1);
      end
      if (state_q == awu_pkg::ST_SQRT || state_q == awu_pkg::ST_DIV) begin
        cnt_q <= cnt_q + STEP_CNT_W'(1);
      end else begin
        cnt_q <= '0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q  <= req_i.weight_index;
      w_q    <= req_i.weight;
      nw_q   <= req_i.weight;
      gneg_q <= req_i.gradient[DATA_W-1];
      gmag_q <= gmag_in;
      sat_q  <= 1'b0;
    end
    case (state_q)
      awu_pkg::ST_SQ: sq_q <= mul_res[FRAC_BITS +: SQ_W];
      awu_pkg::ST_ACC: begin
        sat_q  <= acc_ovf;
        rad_q  <= RAD_W'({d_val, {FRAC_BITS{1'b0}}});
        rem_q  <= '0;
        root_q <= '0;
      end
      awu_pkg::ST_SQRT: begin
        rem_q  <= borrow ? sub_a : diff;
        root_q <= {root_q[ROOT_W-2:0], ~borrow};
        rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      end
      awu_pkg::ST_MUL: begin
        quo_q <= mul_res[PROD_W-1:0];
        rem_q <= '0;
      end
      awu_pkg::ST_DIV: begin
        rem_q <= borrow ? sub_a : diff;
        quo_q <= {quo_q[PROD_W-2:0], ~borrow};
      end
      awu_pkg::ST_FIN: begin
        nw_q  <= nw_clamped;
        sat_q <= sat_q | !nw_in_range;
      end
      default: ;
    endcase
    if (load_out) begin
      out_idx_q <= idx_q;
      out_nw_q  <= nw_q;
      out_sat_q <= sat_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[idx_q];
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_index = out_idx_q;
  assign rsp_o.new_weight   = out_nw_q;
  assign rsp_o.saturated    = out_sat_q;

  `AWU_ASSERT_NOW(a_mem_write_state, mem_we, state_q == awu_pkg::ST_CLEAR || state_q == awu_pkg::ST_IDLE || state_q == awu_pkg::ST_ACC, "Accumulator write outside a write state.")
  `AWU_ASSERT_NOW(a_sqrt_rem_bound, state_q == awu_pkg::ST_SQRT, rem_q <= (SUB_W'(root_q) << 1), "Square root remainder out of bound.")
  `AWU_ASSERT_NOW(a_div_rem_bound, state_q == awu_pkg::ST_DIV, rem_q < SUB_W'(div_s), "Division remainder not below divisor.")
  `AWU_ASSERT_NEXT(a_clear_item_done, accept && req_i.action == awu_pkg::ACT_CLEAR, state_q == awu_pkg::ST_DONE, "Clear item did not go straight to result.")

endmodule

FILE: verif/awu_update_checker.sv
// Scoreboard that predicts each Adagrad weight result and compares it with the block's output.
module awu_update_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [awu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [awu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  awu_in_if                              req_i,
  awu_out_if                             rsp_i,
  output int                             mismatch_count_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import awu_pkg::*;

  localparam logic [63:0] ACC_LIMIT = (64'd1 << ACC_W) - 64'd1;
  localparam logic signed [63:0] WEIGHT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] WEIGHT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [DATA_W-1:0]  weight;
    logic               sat;
  } weight_result_t;

  logic [ACC_W-1:0]   sum_sq_mem [NUM_WEIGHTS];
  logic [LR_W-1:0]    lr_q;
  logic [FUDGE_W-1:0] fudge_q;
  weight_result_t     expected_weights [$];

  function automatic logic [63:0] floor_sqrt80(input logic [79:0] radicand);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] trial;
    int          i;
    rem  = '0;
    root = '0;
    for (i = 39; i >= 0; i--) begin
      rem   = (rem << 2) | 64'(radicand[2*i +: 2]);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic weight_result_t predict_weight(input logic act,
                                                    input logic [INDEX_W-1:0] idx,
                                                    input logic [DATA_W-1:0] wbits,
                                                    input logic [DATA_W-1:0] gbits);
    weight_result_t    res;
    logic [63:0]       gmag;
    logic [63:0]       sq;
    logic [63:0]       acc;
    logic [63:0]       dsum;
    logic [63:0]       root;
    logic [63:0]       prod;
    logic [63:0]       mag;
    logic signed [63:0] w64;
    logic signed [63:0] step;
    logic signed [63:0] nw;
    logic              sat;
    res.index = idx;
    sat       = 1'b0;
    w64       = {{32{wbits[DATA_W-1]}}, wbits};
    nw        = w64;
    gmag      = gbits[DATA_W-1] ? (64'h1_0000_0000 - {32'd0, gbits}) : {32'd0, gbits};
    if (int'(idx) < NUM_WEIGHTS) begin
      if (act == ACT_CLEAR) begin
        sum_sq_mem[idx] = '0;
      end else begin
        sq  = (gmag * gmag) >> FRAC_BITS;
        acc = 64'(sum_sq_mem[idx]) + sq;
        if (acc > ACC_LIMIT) begin
          acc = ACC_LIMIT;
          sat = 1'b1;
        end
        sum_sq_mem[idx] = acc[ACC_W-1:0];
        dsum = acc + 64'(fudge_q);
        root = floor_sqrt80(80'(dsum) << FRAC_BITS);
        if (root == 64'd0) begin
          root = 64'd1;
        end
        prod = 64'(lr_q) * gmag;
        mag  = prod / root;
        step = gbits[DATA_W-1] ? -$signed(mag) : $signed(mag);
        nw   = w64 - step;
        if (nw > WEIGHT_MAX) begin
          nw  = WEIGHT_MAX;
          sat = 1'b1;
        end else if (nw < WEIGHT_MIN) begin
          nw  = WEIGHT_MIN;
          sat = 1'b1;
        end
      end
    end
    res.weight = nw[DATA_W-1:0];
    res.sat    = sat;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    weight_result_t want;
    int             i;
    if (!rst_ni) begin
      for (i = 0; i < NUM_WEIGHTS; i++) begin
        sum_sq_mem[i] = '0;
      end
      lr_q    = LEARNING_RATE_RST;
      fudge_q = INIT_ACCUM_RST;
      expected_weights.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_weights.size() == 0) begin
          $error("result for index %0d arrived with no request waiting", rsp_i.result_index);
          mismatch_count_o++;
        end else begin
          want = expected_weights.pop_front();
          if (rsp_i.result_index !== want.index) begin
            $error("result_index expected %0d actual %0d", want.index, rsp_i.result_index);
            mismatch_count_o++;
          end
          if (rsp_i.new_weight !== want.weight) begin
            $error("new_weight expected %0d actual %0d", $signed(want.weight),
                   $signed(rsp_i.new_weight));
            mismatch_count_o++;
          end
          if (rsp_i.saturated !== want.sat) begin
            $error("saturated expected %0d actual %0d", want.sat, rsp_i.saturated);
            mismatch_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == REG_LEARNING_RATE) begin
          lr_q = cfg_data_i[LR_W-1:0];
        end else if (cfg_index_i == REG_INIT_ACCUM) begin
          fudge_q = cfg_data_i[FUDGE_W-1:0];
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_weights.push_back(predict_weight(req_i.action, req_i.weight_index,
                                                  req_i.weight, req_i.gradient));
      end
      pending_o = expected_weights.size();
    end
  end

endmodule

FILE: verif/tb_adagrad_weight_update_top.sv
// Top-level testbench that drives requests and configuration into the Adagrad weight update block.
module tb_adagrad_weight_update_top;
  timeunit 1ns;
  timeprecision 1ps;
  import awu_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatch_count;
  int                    pending_results;
  int                    cycle_count = 0;
  int                    sender_gap_pct;
  int                    stall_pct;
  int                    stall_left;
  bit                    calm;

  awu_in_if  req_if ();
  awu_out_if rsp_if ();

  adagrad_weight_update_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  awu_update_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .req_i            (req_if),
    .rsp_i            (rsp_if),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_results)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rsp_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        rsp_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic act, input logic [INDEX_W-1:0] idx,
                           input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] g);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < sender_gap_pct) begin
      gap = $urandom_range(1, 17);
    end
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= act;
    req_if.weight_index <= idx;
    req_if.weight       <= w;
    req_if.gradient     <= g;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_results != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_gradient();
    logic [DATA_W-1:0] g;
    case ($urandom_range(0, 7))
      0: g = '0;
      1: g = DATA_W'($urandom_range(1, 4095));
      2: g = 32'h8000_0000;
      3: g = 32'h7FFF_FFFF;
      4: g = 32'h7FFF_FFFF - DATA_W'($urandom_range(0, 65535));
      5: g = DATA_W'($urandom_range(0, 2 ** 25));
      default: g = $urandom();
    endcase
    if ($urandom_range(0, 1) == 1) begin
      g = -g;
    end
    return g;
  endfunction

  function automatic logic [DATA_W-1:0] pick_weight();
    logic [DATA_W-1:0] w;
    case ($urandom_range(0, 5))
      0: w = 32'h7FFF_FFFF;
      1: w = 32'h8000_0000;
      2: w = 32'h7FFF_FFFF - DATA_W'($urandom_range(0, 2 ** 25));
      3: w = 32'h8000_0000 + DATA_W'($urandom_range(0, 2 ** 25));
      default: w = $urandom();
    endcase
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] big_gradient();
    logic [DATA_W-1:0] r;
    r = DATA_W'($urandom_range(0, 65535));
    return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF - r : 32'h8000_0000 + r;
  endfunction

  task automatic send_random();
    logic               act;
    logic [INDEX_W-1:0] idx;
    act = ($urandom_range(0, 9) == 0) ? ACT_CLEAR : ACT_UPDATE;
    if ($urandom_range(0, 1) == 1) begin
      idx = INDEX_W'($urandom_range(0, 7));
    end else begin
      idx = INDEX_W'($urandom_range(0, NUM_WEIGHTS - 1));
    end
    send_item(act, idx, pick_weight(), pick_gradient());
  endtask

  initial begin
    int n;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    req_if.valid        = 1'b0;
    req_if.action       = ACT_UPDATE;
    req_if.weight_index = '0;
    req_if.weight       = '0;
    req_if.gradient     = '0;
    calm                = 1'b0;
    sender_gap_pct      = 10;
    stall_pct           = 10;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(ACT_UPDATE, 10'd0,    32'h0000_0000, 32'h0000_0000);
    send_item(ACT_UPDATE, 10'd1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(ACT_UPDATE, 10'd1023, 32'h8000_0000, 32'h8000_0000);
    send_item(ACT_UPDATE, 10'd1,    32'h8000_0000, 32'h7FFF_FFFF);
    send_item(ACT_UPDATE, 10'd2,    32'h1234_5678, 32'hFFFF_FFFF);
    send_item(ACT_CLEAR,  10'd1023, 32'hDEAD_BEEF, 32'h7FFF_FFFF);
    send_item(ACT_UPDATE, 10'd1023, 32'h0100_0000, 32'h0000_0FFF);
    send_item(ACT_CLEAR,  10'd0,    32'h8000_0000, 32'h8000_0000);
    send_item(ACT_UPDATE, 10'd512,  32'h5555_5555, 32'hAAAA_AAAA);
    send_item(ACT_UPDATE, 10'd341,  32'hAAAA_AAAA, 32'h5555_5555);
    drain_results();

    // With no fudge term and an empty accumulator the root is zero.
    write_reg(REG_LEARNING_RATE, CFG_DATA_W'(2 ** 24));
    write_reg(REG_INIT_ACCUM, '0);
    send_item(ACT_CLEAR,  10'd3, 32'h0000_0000, 32'h0000_0000);
    send_item(ACT_UPDATE, 10'd3, 32'h8000_0000, 32'h0000_0001);
    send_item(ACT_UPDATE, 10'd3, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_UPDATE, 10'd3, 32'h0000_0000, 32'h7FFF_FFFF);
    send_item(ACT_UPDATE, 10'd4, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(ACT_UPDATE, 10'd4, 32'h8000_0000, 32'h0000_0000);
    drain_results();

    write_reg(REG_LEARNING_RATE, '0);
    write_reg(REG_INIT_ACCUM, CFG_DATA_W'(24'hFF_FFFF));
    send_item(ACT_UPDATE, 10'd5, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(ACT_CLEAR,  10'd5, 32'h0000_0001, 32'h0000_0001);
    send_item(ACT_UPDATE, 10'd6, 32'h8000_0000, 32'h8000_0000);
    drain_results();

    write_reg(REG_LEARNING_RATE, CFG_DATA_W'($urandom_range(0, 2 ** 24)));
    write_reg(REG_INIT_ACCUM, CFG_DATA_W'($urandom_range(0, 2 ** 24 - 1)));
    sender_gap_pct = 25;
    stall_pct      = 15;
    for (n = 0; n < 300; n++) begin
      send_random();
    end
    drain_results();

    write_reg(REG_LEARNING_RATE, CFG_DATA_W'(2 ** 24));
    write_reg(REG_INIT_ACCUM, CFG_DATA_W'(24'hFF_FFFF));
    sender_gap_pct = 0;
    stall_pct      = 30;
    for (n = 0; n < 150; n++) begin
      send_random();
    end
    sender_gap_pct = 40;
    stall_pct      = 0;
    for (n = 0; n < 150; n++) begin
      send_random();
    end
    drain_results();

    write_reg(REG_LEARNING_RATE, '0);
    write_reg(REG_INIT_ACCUM, '0);
    sender_gap_pct = 20;
    stall_pct      = 20;
    for (n = 0; n < 100; n++) begin
      send_random();
    end
    drain_results();

    // Large gradients on one entry drive its accumulator into saturation.
    write_reg(REG_LEARNING_RATE, CFG_DATA_W'($urandom_range(0, 2 ** 24)));
    write_reg(REG_INIT_ACCUM, CFG_DATA_W'($urandom_range(0, 255)));
    sender_gap_pct = 15;
    stall_pct      = 15;
    send_item(ACT_CLEAR, 10'd7, pick_weight(), pick_gradient());
    for (n = 0; n < 1040; n++) begin
      if (n == 800) begin
        calm = 1'b1;
      end
      send_item(ACT_UPDATE, 10'd7, pick_weight(), big_gradient());
      if ($urandom_range(0, 9) == 0) begin
        send_random();
      end
    end
    drain_results();
    repeat (200) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
